/* rtl/core/sha256_pkg.sv */
// SHA-256 stream hasher package: round constants, initial hash, helpers.
// Used by all modules of the hasher.
`default_nettype none
package sha256_pkg;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned QueueDepth = 4;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       last;
  } item_t;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_PAD,
    ST_ROUNDS,
    ST_EMIT
  } back_state_t;

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[t];
  endfunction

  function automatic logic [31:0] init_h(input logic [2:0] i);
    logic [31:0] h [8];
    h = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
          32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
    return h[i];
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
    return (v >> n) | (v << (32 - n));
  endfunction
endpackage
`default_nettype wire

/* rtl/core/sha256_stream_hasher.sv */
// SHA-256 stream hasher, top level: byte queue front end feeding the compression back end.
// Each full block runs 64 rounds; a last beat adds one or two padded blocks of 64 rounds,
// then eight digest beats. Throughput: one byte per cycle while collecting, rounds stall input.
// The 64-round loop of the single compression unit sets the rate.
// Reset: synchronous active-low; loads the initial hash values and clears counts.
`default_nettype none
module sha256_stream_hasher #(
  parameter int unsigned QueueDepth = sha256_pkg::QueueDepth
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // msg_byte
  input  wire         in_tuser,   // byte_valid
  input  wire         in_tlast,   // last
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [39:0] out_tdata,  // digest_word[31:0], word_index[34:32]
  output logic        out_tlast   // digest_last
);
  import sha256_pkg::*;
  logic  q_valid, q_pop;
  item_t q_item;

  sha256_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .q_valid, .q_pop, .q_item);

  sha256_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast);
endmodule
`default_nettype wire

/* rtl/core/sha256_front.sv */
// Input front: accepts byte beats and queues those that carry a byte or last for the back end.
// Depends on sha256_pkg.
`default_nettype none
module sha256_front #(
  parameter int unsigned Depth = sha256_pkg::QueueDepth
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_tvalid,
  output logic                 in_tready,
  input  wire  [7:0]           in_tdata,  // msg_byte
  input  wire                  in_tuser,  // byte_valid
  input  wire                  in_tlast,  // last
  output logic                 q_valid,
  input  wire                  q_pop,
  output sha256_pkg::item_t    q_item
);
  import sha256_pkg::*;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  item_t          mem_r [Depth];
  logic [AW-1:0]  wp_r, rp_r;
  logic [AW:0]    cnt_r;
  logic           push;

  assign in_tready = (cnt_r != (AW+1)'(Depth));
  assign push      = in_tvalid && in_tready && (in_tuser || in_tlast);
  assign q_valid   = (cnt_r != '0);
  assign q_item    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= '{msg_byte: in_tdata, byte_valid: in_tuser, last: in_tlast};
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (q_pop) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end
endmodule
`default_nettype wire

/* rtl/core/sha256_back.sv */
// Back end: block buffer, padding, message schedule, 64-round compression, digest out.
// Depends on sha256_pkg.
`default_nettype none
module sha256_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  q_valid,
  output logic                 q_pop,
  input  sha256_pkg::item_t    q_item,
  output logic                 out_tvalid,
  input  wire                  out_tready,
  output logic [39:0]          out_tdata,  // digest_word[31:0], word_index[34:32], zero pad
  output logic                 out_tlast   // digest_last
);
  import sha256_pkg::*;

  back_state_t   st_r, st_nxt;
  logic [31:0]   w_r [16];
  logic [31:0]   h_r [8];
  logic [31:0]   a_r [8];
  logic [5:0]    fill_r;
  logic [63:0]   bits_r;
  logic [5:0]    rnd_r;
  logic          fin_r;
  logic [2:0]    oidx_r;
  logic          second_r;

  logic [31:0] wt, s0, s1, wnew, t1, t2, e, a;
  logic        take, go_round, pad_two;

  assign take = (st_r == ST_COLLECT) && q_valid;
  assign q_pop = take;

  always_comb begin
    wt   = w_r[0];
    s0   = rotr(w_r[1], 7) ^ rotr(w_r[1], 18) ^ (w_r[1] >> 3);
    s1   = rotr(w_r[14], 17) ^ rotr(w_r[14], 19) ^ (w_r[14] >> 10);
    wnew = s1 + w_r[9] + s0 + w_r[0];
    e    = a_r[4];
    a    = a_r[0];
    t1   = a_r[7] + (rotr(e,6) ^ rotr(e,11) ^ rotr(e,25)) + ((e & a_r[5]) ^ (~e & a_r[6]))
           + round_k(rnd_r) + wt;
    t2   = (rotr(a,2) ^ rotr(a,13) ^ rotr(a,22)) ^ 32'h0;
    t2   = t2 + ((a & a_r[1]) ^ (a & a_r[2]) ^ (a_r[1] & a_r[2]));
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_COLLECT: if (take) begin
        if (q_item.byte_valid && fill_r == 6'd63) st_nxt = ST_ROUNDS;
        else if (q_item.last) st_nxt = ST_PAD;
      end
      ST_PAD:    st_nxt = ST_ROUNDS;
      ST_ROUNDS: if (rnd_r == 6'd63) begin
        if (fin_r && !second_r) st_nxt = ST_PAD;
        else if (fin_r) st_nxt = ST_EMIT;
        else st_nxt = ST_COLLECT;
      end
      ST_EMIT:   if (out_tready && oidx_r == 3'd7) st_nxt = ST_COLLECT;
      default:   st_nxt = ST_COLLECT;
    endcase
  end

  always_comb begin
    out_tvalid = (st_r == ST_EMIT);
    out_tdata  = {5'd0, oidx_r, h_r[oidx_r]};
    out_tlast  = (oidx_r == 3'd7);
  end

  // pad_two: after 0x80 more than 56 bytes are used, length goes in a second block
  assign pad_two = (fill_r > 6'd55);
  assign go_round = (st_r == ST_ROUNDS);

  always_ff @(posedge clk) begin
    if (take && q_item.byte_valid)
      w_r[fill_r[5:2]][8*(3-fill_r[1:0]) +: 8] <= q_item.msg_byte;
    if (st_r == ST_PAD) begin
      for (int i = 0; i < 16; i++) begin
        if ((second_r || !pad_two) && i >= 14) begin
          w_r[i] <= (i == 14) ? bits_r[63:32] : bits_r[31:0];
        end else begin
          for (int b = 0; b < 4; b++) begin
            if (second_r) w_r[i][8*(3-b) +: 8] <= 8'h00;
            else if (6'(4*i+b) == fill_r) w_r[i][8*(3-b) +: 8] <= 8'h80;
            else if (6'(4*i+b) > fill_r) w_r[i][8*(3-b) +: 8] <= 8'h00;
          end
        end
      end
    end
    if (go_round) begin
      for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
      w_r[15] <= wnew;
      a_r[7] <= a_r[6]; a_r[6] <= a_r[5]; a_r[5] <= a_r[4]; a_r[4] <= a_r[3] + t1;
      a_r[3] <= a_r[2]; a_r[2] <= a_r[1]; a_r[1] <= a_r[0]; a_r[0] <= t1 + t2;
    end else begin
      for (int i = 0; i < 8; i++) a_r[i] <= h_r[i];
    end
    if (!rst_n) begin
      st_r <= ST_COLLECT; fill_r <= '0; bits_r <= '0; rnd_r <= '0; fin_r <= 1'b0;
      oidx_r <= '0; second_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else begin
      st_r <= st_nxt;
      if (take) begin
        if (q_item.byte_valid) begin
          fill_r <= fill_r + 6'd1;
          bits_r <= bits_r + 64'd8;
        end
        fin_r <= q_item.last;
        second_r <= 1'b0;
      end
      if (st_r == ST_PAD && !second_r) begin
        // mark the length as placed when it fits after 0x80; else a second block follows
        second_r <= !pad_two;
      end
      if (st_r == ST_PAD && second_r) second_r <= 1'b1;
      if (go_round) begin
        rnd_r <= rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          h_r[0] <= h_r[0] + t1 + t2; h_r[1] <= h_r[1] + a_r[0];
          h_r[2] <= h_r[2] + a_r[1];  h_r[3] <= h_r[3] + a_r[2];
          h_r[4] <= h_r[4] + a_r[3] + t1; h_r[5] <= h_r[5] + a_r[4];
          h_r[6] <= h_r[6] + a_r[5];  h_r[7] <= h_r[7] + a_r[6];
          if (fin_r && !second_r && pad_two) second_r <= 1'b1;
        end
      end
      if (st_r == ST_EMIT && out_tready) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
          fill_r <= '0; bits_r <= '0; fin_r <= 1'b0; second_r <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

/* test/sha256_stream_hasher_test.sv */
// Testbench for sha256_stream_hasher: byte beats in, digest words out, checked against
// a SHA-256 predictor built into this file. Depends on the RTL top level only.
`default_nettype none
module sha256_stream_hasher_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 2000000;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic        out_tlast;

  sha256_stream_hasher dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  logic [31:0] k_tab [64] = '{
    32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
    32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
    32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
    32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
    32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
    32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
    32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
    32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
    32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
    32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
    32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
  logic [31:0] h_init [8] = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
                              32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

  logic [31:0]  hash_state [8];
  logic [7:0]   block_bytes [64];
  int unsigned  fill_level;
  logic [63:0]  msg_bits;
  digest_beat_t digest_queue [$];

  int unsigned  send_idle_pct = 0;
  int unsigned  recv_stall_pct = 0;
  int unsigned  hold_off_cycles = 0;
  int unsigned  mismatches = 0;
  int unsigned  cycle_count = 0;

  function automatic logic [31:0] ror(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] r [8];
    logic [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    for (int i = 0; i < 8; i++) r[i] = hash_state[i];
    for (int t = 0; t < 64; t++) begin
      t1 = r[7] + (ror(r[4], 6) ^ ror(r[4], 11) ^ ror(r[4], 25))
         + ((r[4] & r[5]) ^ (~r[4] & r[6])) + k_tab[t] + w[t];
      t2 = (ror(r[0], 2) ^ ror(r[0], 13) ^ ror(r[0], 22))
         + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
      r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
      r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += r[i];
  endtask

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = h_init[i];
    fill_level = 0;
    msg_bits = '0;
  endtask

  task automatic predict_digest(logic [7:0] b, logic valid, logic fin);
    if (valid) begin
      block_bytes[fill_level] = b;
      fill_level++;
      msg_bits += 64'd8;
      if (fill_level == 64) begin
        compress_block();
        fill_level = 0;
      end
    end
    if (fin) begin
      block_bytes[fill_level++] = 8'h80;
      if (fill_level > 56) begin
        while (fill_level < 64) block_bytes[fill_level++] = 8'h00;
        compress_block();
        fill_level = 0;
      end
      while (fill_level < 56) block_bytes[fill_level++] = 8'h00;
      for (int i = 0; i < 8; i++) block_bytes[56+i] = msg_bits[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++)
        digest_queue.push_back('{word: hash_state[i], index: 3'(i), last: (i == 7)});
      restart_hash();
    end
  endtask

  task automatic send_beat(logic [7:0] b, logic valid, logic fin);
    while ($urandom_range(99) < send_idle_pct) @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata  = b;
    in_tuser  = valid;
    in_tlast  = fin;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_digest(b, valid, fin);
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic send_message(int unsigned len, bit last_carries_byte);
    for (int unsigned i = 0; i < len; i++)
      send_beat(8'($urandom), 1'b1, last_carries_byte && (i == len - 1));
    if (!last_carries_byte || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    while (digest_queue.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic test_directed();
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h61, 1'b1, 1'b0);
    send_beat(8'h62, 1'b1, 1'b0);
    send_beat(8'h63, 1'b1, 1'b1);
    send_beat(8'hff, 1'b0, 1'b0);
    send_beat(8'hff, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'h5a, 1'b0, 1'b0);
    send_beat(8'ha5, 1'b0, 1'b1);
    wait_drained();
  endtask

  task automatic test_pad_edges();
    send_message(55, 1'b1);
    send_message(56, 1'b0);
    send_message(64, 1'b1);
    wait_drained();
  endtask

  task automatic test_random(int unsigned beats);
    int unsigned sent = 0;
    int unsigned len;
    while (sent < beats) begin
      if ($urandom_range(9) == 0) begin
        send_beat(8'($urandom), 1'b0, 1'b0);
        sent++;
      end else begin
        len = ($urandom_range(7) == 0) ? $urandom_range(80) : $urandom_range(20);
        send_message(len, 1'($urandom_range(1)));
        sent += len + 1;
      end
    end
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 300;
    send_message(20, 1'b0);
    send_message(10, 1'b1);
    send_message(0, 1'b0);
    wait_drained();
  endtask

  always @(posedge clk) begin
    digest_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected digest beat %h last %b", out_tdata, out_tlast);
      end else begin
        want = digest_queue.pop_front();
        if (out_tdata[31:0] !== want.word || out_tdata[34:32] !== want.index
            || out_tdata[39:35] !== '0 || out_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest mismatch: expected %h idx %0d last %b, got %h idx %0d last %b",
                     want.word, want.index, want.last, out_tdata[31:0], out_tdata[34:32],
                     out_tlast);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off_cycles != 0) begin
      out_tready <= 1'b0;
      hold_off_cycles--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("** sha256_stream_hasher: FAILED **");
      $finish;
    end
  end

  initial begin
    restart_hash();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_pad_edges();
    test_random(35);
    send_idle_pct = 62;
    test_random(35);
    wait_drained();
    send_idle_pct = 0;
    recv_stall_pct = 62;
    test_random(35);
    send_idle_pct = 37;
    recv_stall_pct = 37;
    test_random(35);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_backpressure();
    wait_drained();
    if (mismatches == 0 && digest_queue.size() == 0) begin
      $display("** sha256_stream_hasher: PASSED **");
    end else begin
      $display("** sha256_stream_hasher: FAILED **");
    end
    $finish;
  end
endmodule
`default_nettype wire
